>>> rtl/swms_pkg.sv
package swms_pkg;

  localparam int PRICE_W = 30;
  localparam int AGE_W   = 11;
  localparam int WSIZE_W = 11;
  localparam int TOTAL_W = 63;

  // one queue entry
  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [AGE_W-1:0]   age;
  } swms_cell_t;

  // broadcast to every cell
  typedef struct packed {
    logic               prune;    // drop the front entry, shift everything forward
    logic               accept;   // a request is taken this cycle
    logic               shift;    // front entry leaves the window with this request
    logic               restart;
    logic [PRICE_W-1:0] price;
  } swms_ctl_t;

endpackage

>>> rtl/swms_cell.sv
module swms_cell (
  input  logic                clk,
  input  logic                rst,
  input  swms_pkg::swms_ctl_t  ctl,
  input  swms_pkg::swms_cell_t up,
  input  logic                up_keep,
  input  logic                prev_keep,
  output swms_pkg::swms_cell_t st,
  output logic                keep
);
  import swms_pkg::*;

  swms_cell_t src;
  logic       src_keep;

  // entry survives the new price (strictly lower) and no restart clears it
  assign keep = st.valid && (st.price < ctl.price) && !ctl.restart;

  assign src      = ctl.shift ? up : st;
  assign src_keep = ctl.shift ? up_keep : keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else if (ctl.prune) begin
      st <= up;
    end else if (ctl.accept) begin
      if (src_keep) begin
        st.valid <= 1'b1;
        st.price <= src.price;
        st.age   <= src.age + AGE_W'(1);
      end else if (prev_keep) begin
        // first slot past the survivors takes the new price
        st.valid <= 1'b1;
        st.price <= ctl.price;
        st.age   <= '0;
      end else begin
        st.valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/sliding_window_min_sum.sv
// result: registered in the cycle after the request is taken
// throughput: one item per cycle while the result side keeps up
// after window_size is lowered, requests stall while the front entries past the first
//   that fell out of the window drain (the queue drains one entry per cycle)
// reset: queue empty, running total zero, window_size 1
module sliding_window_min_sum #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // price[29:0]
  input  logic [0:0]  s_tuser,   // restart[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // window_min[29:0], running_total[92:30]
  input  logic        cfg_we,
  input  logic [swms_pkg::WSIZE_W-1:0] cfg_data
);
  import swms_pkg::*;

  logic [WSIZE_W-1:0] window_size;
  logic [WSIZE_W-1:0] w_eff;
  swms_cell_t         st   [MAX_WINDOW+1];
  logic               keep [MAX_WINDOW+1];
  swms_ctl_t          ctl;
  logic               acc;
  logic               drop0;
  logic               prune_need;
  logic [PRICE_W-1:0] price;
  logic [PRICE_W-1:0] min_next;
  logic [PRICE_W-1:0] out_min;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] base;
  logic [TOTAL_W:0]   sum;

  always_comb begin
    if (window_size == '0) begin
      w_eff = WSIZE_W'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      w_eff = WSIZE_W'(MAX_WINDOW);
    end else begin
      w_eff = window_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_W'(1);
    end else if (cfg_we) begin
      window_size <= cfg_data;
    end
  end

  assign price = s_tdata[PRICE_W-1:0];

  // front is the oldest entry; only it may age out with a request
  assign drop0 = st[0].valid &&
                 (({1'b0, st[0].age} + (AGE_W+1)'(1)) >= {1'b0, w_eff});
  // two or more entries past the window after a shrink: drain one first
  assign prune_need = st[0].valid && st[1].valid &&
                      (({1'b0, st[1].age} + (AGE_W+1)'(1)) >= {1'b0, w_eff});

  assign s_tready = !prune_need && (!m_tvalid || m_tready);
  assign acc      = s_tvalid && s_tready;

  assign ctl.prune   = prune_need;
  assign ctl.accept  = acc;
  assign ctl.shift   = drop0;
  assign ctl.restart = s_tuser[0];
  assign ctl.price   = price;

  assign st[MAX_WINDOW]   = '0;
  assign keep[MAX_WINDOW] = 1'b0;

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    logic prev_keep;
    if (j == 0) begin : g_head
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_keep = ctl.shift ? keep[j] : keep[j-1];
    end
    swms_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .up        (st[j+1]),
      .up_keep   (keep[j+1]),
      .prev_keep (prev_keep),
      .st        (st[j]),
      .keep      (keep[j])
    );
  end

  // new front of the queue after this request
  always_comb begin
    if (drop0) begin
      min_next = keep[1] ? st[1].price : price;
    end else begin
      min_next = keep[0] ? st[0].price : price;
    end
  end

  assign base = ctl.restart ? '0 : total;
  assign sum  = {1'b0, base} + (TOTAL_W+1)'(min_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      total    <= '0;
    end else begin
      if (acc) begin
        m_tvalid <= 1'b1;
        out_min  <= min_next;
        total    <= sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {3'b000, total, out_min};

`ifndef SYNTHESIS
  a_front_valid: assert property (@(posedge clk) disable iff (rst)
    acc |=> st[0].valid)
    else $error("queue front empty after a request");

  a_prune_blocks: assert property (@(posedge clk) disable iff (rst)
    prune_need |-> !s_tready)
    else $error("request taken while draining aged entries");

  a_front_age: assert property (@(posedge clk) disable iff (rst)
    acc |=> ({1'b0, st[0].age} < {1'b0, w_eff}))
    else $error("front entry older than the window");

  a_total_grows: assert property (@(posedge clk) disable iff (rst)
    (acc && !s_tuser[0]) |=> (total >= $past(total)))
    else $error("running total decreased within a run");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> m_tvalid && (m_tdata[PRICE_W-1:0] == st[0].price))
    else $error("result does not match queue front");
`endif

endmodule
